// ===== hdl/tlrs_pkg.sv =====
// Shared types and constants for the timestamped log range search core.
`default_nettype none
package tlrs_pkg;

  localparam int unsigned DEFAULT_LOG_DEPTH = 1024;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned NUM_W = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FIND = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic done;
    logic not_found;
  } tlrs_seq_status_t;

endpackage
`default_nettype wire

// ===== hdl/timestamped_log_range_search_core.sv =====
// Append: result in the output register in the cycle after the item is accepted.
// Find on an empty log: EMPTY result in the next cycle. Find out of span: NOT_FOUND after the oldest or newest check.
// Find in span: binary search in a compare/halving loop through the single RAM read port.
// One item at a time; in_ready is low while a find runs.
// Synchronous reset clears the counters; the time RAM is not cleared.
`default_nettype none
module timestamped_log_range_search_core #(
  parameter int unsigned LOG_DEPTH = tlrs_pkg::DEFAULT_LOG_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            operation,
  input  wire logic [tlrs_pkg::TIME_W-1:0]     entry_time,
  input  wire logic [tlrs_pkg::TIME_W-1:0]     query_time,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [tlrs_pkg::STATUS_W-1:0]   status,
  output logic      [tlrs_pkg::NUM_W-1:0]      entry_number
);
  import tlrs_pkg::*;

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam int unsigned FW = $clog2(LOG_DEPTH + 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(LOG_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(LOG_DEPTH - 1);

  logic              busy;
  logic [NUM_W-1:0]  next_number;
  logic [FW-1:0]     fill;
  logic [AW-1:0]     write_slot;

  logic              accept;
  logic              do_append;
  logic              do_find;
  logic              seq_start;
  logic [AW-1:0]     oldest_slot;
  logic [AW-1:0]     rd_addr;
  logic [TIME_W-1:0] rd_data;
  logic [AW-1:0]     found_pos;
  tlrs_seq_status_t  seq_stat;

  assign in_ready  = !busy && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign do_append = accept && (operation == OP_APPEND);
  assign do_find   = accept && (operation == OP_FIND);
  assign seq_start = do_find && (fill != '0);

  // until the ring wraps, the oldest entry sits in slot zero
  assign oldest_slot = (fill == DEPTH_F) ? write_slot : '0;

  tlrs_ram #(
    .WIDTH (TIME_W),
    .DEPTH (LOG_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_append),
    .waddr (write_slot),
    .wdata (entry_time),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  tlrs_seq #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (seq_start),
    .query_time  (query_time),
    .fill        (fill),
    .oldest_slot (oldest_slot),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .stat        (seq_stat),
    .found_pos   (found_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      next_number <= '0;
      fill        <= '0;
      write_slot  <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_append) begin
        out_valid   <= 1'b1;
        next_number <= next_number + NUM_W'(1);
        write_slot  <= (write_slot == LAST_SLOT) ? '0 : write_slot + AW'(1);
        if (fill != DEPTH_F) begin
          fill <= fill + FW'(1);
        end
      end
      if (do_find) begin
        if (fill == '0) begin
          out_valid <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end
      // output register is free here: a find starts only with it drained
      if (seq_stat.done) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      status       <= ST_OK;
      entry_number <= next_number;
    end else if (do_find && (fill == '0)) begin
      status       <= ST_EMPTY;
      entry_number <= '0;
    end else if (seq_stat.done) begin
      if (seq_stat.not_found) begin
        status       <= ST_NOT_FOUND;
        entry_number <= '0;
      end else begin
        status       <= ST_OK;
        entry_number <= next_number - NUM_W'(fill) + NUM_W'(found_pos);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tlrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tlrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/tlrs_seq.sv =====
// Find sequencer: span checks and binary search over the ring through one compare unit.
`default_nettype none
module tlrs_seq #(
  parameter int unsigned LOG_DEPTH = tlrs_pkg::DEFAULT_LOG_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [tlrs_pkg::TIME_W-1:0]        query_time,
  input  wire logic [$clog2(LOG_DEPTH+1)-1:0]     fill,
  input  wire logic [$clog2(LOG_DEPTH)-1:0]       oldest_slot,
  output logic      [$clog2(LOG_DEPTH)-1:0]       rd_addr,
  input  wire logic [tlrs_pkg::TIME_W-1:0]        rd_data,
  output tlrs_pkg::tlrs_seq_status_t              stat,
  output logic      [$clog2(LOG_DEPTH)-1:0]       found_pos
);
  import tlrs_pkg::*;

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam int unsigned FW = $clog2(LOG_DEPTH + 1);
  localparam logic [AW:0] DEPTH_S = (AW + 1)'(LOG_DEPTH);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_OLD_ADDR = 3'd1;
  localparam logic [2:0] S_OLD_CHK  = 3'd2;
  localparam logic [2:0] S_NEW_CHK  = 3'd3;
  localparam logic [2:0] S_MID      = 3'd4;
  localparam logic [2:0] S_BIN_ADDR = 3'd5;
  localparam logic [2:0] S_BIN_CHK  = 3'd6;

  logic [2:0]        state;
  logic [TIME_W-1:0] query;
  logic [AW-1:0]     lo;
  logic [AW-1:0]     hi;
  logic [AW-1:0]     rd_pos;
  logic              done;
  logic              not_found;

  logic [AW-1:0]     mid;
  logic [AW:0]       slot_sum;
  logic [AW-1:0]     last_pos;
  logic              d_lt_q;
  logic              d_gt_q;

  // shared compare unit: stored time against the query
  assign d_lt_q = (rd_data < query);
  assign d_gt_q = !d_lt_q && (rd_data != query);

  assign mid      = lo + ((hi - lo) >> 1);
  assign last_pos = AW'(fill - FW'(1));

  // ring position to slot, sum stays below twice the depth
  assign slot_sum = {1'b0, oldest_slot} + {1'b0, rd_pos};
  assign rd_addr  = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : slot_sum[AW-1:0];

  assign stat.done      = done;
  assign stat.not_found = not_found;
  assign found_pos      = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      not_found <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_OLD_ADDR;
          end
        end
        S_OLD_ADDR: begin
          state <= S_OLD_CHK;
        end
        S_OLD_CHK: begin
          if (d_gt_q) begin
            done      <= 1'b1;
            not_found <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_NEW_CHK;
          end
        end
        S_NEW_CHK: begin
          if (d_lt_q) begin
            done      <= 1'b1;
            not_found <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_MID;
          end
        end
        S_MID: begin
          if (lo < hi) begin
            state <= S_BIN_ADDR;
          end else begin
            done      <= 1'b1;
            not_found <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_BIN_ADDR: begin
          state <= S_BIN_CHK;
        end
        S_BIN_CHK: begin
          state <= S_MID;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // search window and read position
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          query  <= query_time;
          lo     <= '0;
          hi     <= last_pos;
          rd_pos <= '0;
        end
      end
      S_OLD_ADDR: begin
        rd_pos <= hi;
      end
      S_MID: begin
        if (lo < hi) begin
          rd_pos <= mid;
        end
      end
      S_BIN_CHK: begin
        if (d_lt_q) begin
          lo <= rd_pos + AW'(1);
        end else begin
          hi <= rd_pos;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/tlrs_checker.sv =====
// Port-level checks for the log search core, bound to the top level.
`default_nettype none
module tlrs_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          operation,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [tlrs_pkg::STATUS_W-1:0] status,
  input wire logic [tlrs_pkg::NUM_W-1:0]    entry_number
);
  import tlrs_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_number))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_NOT_FOUND || status == ST_EMPTY))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (entry_number == '0))
    else $error("failed find carries a nonzero entry number");

  a_append_next: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_APPEND) |=> out_valid && (status == ST_OK))
    else $error("append result not presented on the next cycle");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind timestamped_log_range_search_core tlrs_checker u_tlrs_checker (.*);
`default_nettype wire
